// File: rtl/core/bsm_pkg.sv
`default_nettype none

package bsm_pkg;

    localparam int WIDTH  = 32;
    localparam int OP_W   = 32;
    localparam int PROD_W = 64;
    localparam int ACC_W  = WIDTH + 1;
    localparam int CNT_W  = $clog2(WIDTH + 1);

    localparam logic [1:0] BOOTH_SUB = 2'b10;
    localparam logic [1:0] BOOTH_ADD = 2'b01;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } bsm_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic load_out;
    } bsm_cmd_t;

    typedef struct packed {
        logic last_iter;
    } bsm_status_t;

endpackage

`default_nettype wire

// File: rtl/core/booth_signed_multiplier.sv
// radix-2 booth multiplier, one add/subtract and shift per operand bit
// an accepted beat is loaded in idle, stepped in run to the last iteration, then written out in hold
// a new beat is taken only in idle, after the last one has left the shared add/shift iteration
// a finished product waits in the output register while the next beat is taken
// reset: rst_n clears controller state and output valid, datapath registers are not reset
`default_nettype none

module booth_signed_multiplier (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [bsm_pkg::OP_W-1:0] multiplicand,
    input  wire logic signed [bsm_pkg::OP_W-1:0] multiplier,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [bsm_pkg::PROD_W-1:0]    product
);

    bsm_pkg::bsm_cmd_t    cmd;
    bsm_pkg::bsm_status_t status;

    bsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bsm_datapath u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .multiplicand (multiplicand),
        .multiplier   (multiplier),
        .status       (status),
        .product      (product)
    );

    // a waiting product is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.load_out)
        else $error("product overwritten before taken");

    // each input beat leads to a step with the last iteration flag set
    a_iter_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##(bsm_pkg::WIDTH) (cmd.step && status.last_iter))
        else $error("iteration count mismatch");

    // no new beat while an item is in work
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !in_ready)
        else $error("input taken during iteration");

    // load and output write never coincide with stepping
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.load_out}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// File: rtl/core/bsm_datapath.sv
`default_nettype none

module bsm_datapath (
    input  wire logic                                clk,
    input  wire bsm_pkg::bsm_cmd_t                   cmd,
    input  wire logic signed [bsm_pkg::OP_W-1:0]     multiplicand,
    input  wire logic signed [bsm_pkg::OP_W-1:0]     multiplier,
    output bsm_pkg::bsm_status_t                     status,
    output logic signed [bsm_pkg::PROD_W-1:0]        product
);

    logic [bsm_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [bsm_pkg::ACC_W-1:0]   mcand_reg, mcand_next;
    logic [bsm_pkg::WIDTH-1:0]   q_reg, q_next;
    logic                        q1_reg, q1_next;
    logic [bsm_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [bsm_pkg::PROD_W-1:0]  product_reg, product_next;
    logic [bsm_pkg::ACC_W-1:0]   sum;
    logic [2*bsm_pkg::WIDTH-1:0] raw_product;

    // booth recode of the low pair
    always_comb
    begin
        case ({q_reg[0], q1_reg})
            bsm_pkg::BOOTH_SUB: sum = acc_reg - mcand_reg;
            bsm_pkg::BOOTH_ADD: sum = acc_reg + mcand_reg;
            default:            sum = acc_reg;
        endcase
    end

    assign raw_product = {acc_reg[bsm_pkg::WIDTH-1:0], q_reg};

    always_comb
    begin
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        q_next       = q_reg;
        q1_next      = q1_reg;
        count_next   = count_reg;
        product_next = product_reg;
        if (cmd.load)
        begin
            acc_next   = '0;
            mcand_next = bsm_pkg::ACC_W'($signed(multiplicand[bsm_pkg::WIDTH-1:0]));
            q_next     = multiplier[bsm_pkg::WIDTH-1:0];
            q1_next    = 1'b0;
            count_next = '0;
        end
        else if (cmd.step)
        begin
            // arithmetic right shift of acc, q and extra bit together
            acc_next   = {sum[bsm_pkg::ACC_W-1], sum[bsm_pkg::ACC_W-1:1]};
            q_next     = {sum[0], q_reg[bsm_pkg::WIDTH-1:1]};
            q1_next    = q_reg[0];
            count_next = count_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            product_next = bsm_pkg::PROD_W'($signed(raw_product));
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        q_reg       <= q_next;
        q1_reg      <= q1_next;
        count_reg   <= count_next;
        product_reg <= product_next;
    end

    assign status.last_iter = (count_reg == bsm_pkg::CNT_W'(bsm_pkg::WIDTH - 1));
    assign product          = product_reg;

endmodule

`default_nettype wire

// File: rtl/core/bsm_ctrl.sv
`default_nettype none

module bsm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire bsm_pkg::bsm_status_t status,
    output bsm_pkg::bsm_cmd_t        cmd
);

    bsm_pkg::bsm_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsm_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = bsm_pkg::ST_RUN;
            end
            bsm_pkg::ST_RUN:
            begin
                if (status.last_iter)
                    state_next = bsm_pkg::ST_HOLD;
            end
            bsm_pkg::ST_HOLD:
            begin
                if (out_free)
                    state_next = bsm_pkg::ST_IDLE;
            end
            default: state_next = bsm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            bsm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            bsm_pkg::ST_RUN:  cmd.step     = 1'b1;
            bsm_pkg::ST_HOLD: cmd.load_out = out_free;
            default:          in_ready     = 1'b0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: tb/booth_signed_multiplier_test.sv
module booth_signed_multiplier_test;

    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 400;
    localparam int NUM_PHASES = 4;

    localparam logic [bsm_pkg::OP_W-1:0] OPER_MIN =
        bsm_pkg::OP_W'(1) << (bsm_pkg::WIDTH - 1);
    localparam logic [bsm_pkg::OP_W-1:0] OPER_MAX = OPER_MIN - 1'b1;
    localparam logic [bsm_pkg::OP_W-1:0] ALL_ONES = '1;
    localparam logic [bsm_pkg::OP_W-1:0] ALT_LOW  = {(bsm_pkg::OP_W / 2){2'b01}};
    localparam logic [bsm_pkg::OP_W-1:0] ALT_HIGH = {(bsm_pkg::OP_W / 2){2'b10}};

    typedef struct packed {
        logic [bsm_pkg::OP_W-1:0] mcand;
        logic [bsm_pkg::OP_W-1:0] mplier;
    } operand_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [bsm_pkg::OP_W-1:0] multiplicand = '0;
    logic [bsm_pkg::OP_W-1:0] multiplier = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [bsm_pkg::PROD_W-1:0] product;

    operand_pair_t pending_operands[$];
    logic [bsm_pkg::PROD_W-1:0] expected_products[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int products_checked = 0;
    int pairs_queued = 0;
    int mismatch_count = 0;

    booth_signed_multiplier u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .multiplicand (multiplicand),
        .multiplier   (multiplier),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .product      (product)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // radix-2 booth recoding over WIDTH steps with a WIDTH+1 bit accumulator
    function automatic logic [bsm_pkg::PROD_W-1:0] booth_product(
        logic [bsm_pkg::OP_W-1:0] mcand,
        logic [bsm_pkg::OP_W-1:0] mplier);
        logic [bsm_pkg::ACC_W-1:0] acc;
        logic [bsm_pkg::ACC_W-1:0] mcand_ext;
        logic [bsm_pkg::WIDTH-1:0] q;
        logic q_prev;
        logic signed [2*bsm_pkg::WIDTH-1:0] full;
        acc = '0;
        q_prev = 1'b0;
        mcand_ext = {mcand[bsm_pkg::WIDTH-1], mcand[bsm_pkg::WIDTH-1:0]};
        q = mplier[bsm_pkg::WIDTH-1:0];
        for (int i = 0; i < bsm_pkg::WIDTH; i++)
        begin
            if ({q[0], q_prev} == bsm_pkg::BOOTH_SUB)
                acc = acc - mcand_ext;
            else if ({q[0], q_prev} == bsm_pkg::BOOTH_ADD)
                acc = acc + mcand_ext;
            q_prev = q[0];
            q = {acc[0], q[bsm_pkg::WIDTH-1:1]};
            acc = {acc[bsm_pkg::ACC_W-1], acc[bsm_pkg::ACC_W-1:1]};
        end
        full = {acc[bsm_pkg::WIDTH-1:0], q};
        return full;
    endfunction

    function automatic logic [bsm_pkg::OP_W-1:0] pick_operand();
        logic [bsm_pkg::OP_W-1:0] v;
        case ($urandom_range(9))
            0, 1:    v = bsm_pkg::OP_W'($urandom_range(30)) - bsm_pkg::OP_W'(15);
            2:       v = OPER_MIN + bsm_pkg::OP_W'($urandom_range(7));
            3:       v = OPER_MAX - bsm_pkg::OP_W'($urandom_range(7));
            4:       v = bsm_pkg::OP_W'(1) << $urandom_range(bsm_pkg::OP_W - 1);
            5:       v = ~(bsm_pkg::OP_W'(1) << $urandom_range(bsm_pkg::OP_W - 1));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic queue_pair(logic [bsm_pkg::OP_W-1:0] mcand,
                              logic [bsm_pkg::OP_W-1:0] mplier);
        pending_operands.push_back('{mcand: mcand, mplier: mplier});
        pairs_queued++;
    endtask

    // sender: holds each beat until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_operands.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                multiplicand <= pending_operands[0].mcand;
                multiplier <= pending_operands[0].mplier;
                pending_operands.delete(0);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        logic [bsm_pkg::PROD_W-1:0] want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_products.size() == 0)
                begin
                    $display("%0t unexpected product beat: expected none, actual %h",
                             $time, product);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_products.pop_front();
                    products_checked++;
                    if (product !== want)
                    begin
                        $display("%0t product mismatch: expected %h, actual %h",
                                 $time, want, product);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_products.push_back(booth_product(multiplicand, multiplier));
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int idle_pct[NUM_PHASES];
        int stall_pct[NUM_PHASES];
        idle_pct = '{0, 88, 0, 29};
        stall_pct = '{0, 0, 88, 29};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_pair('0, '0);
        queue_pair(1, 1);
        queue_pair(ALL_ONES, ALL_ONES);
        queue_pair(OPER_MAX, OPER_MAX);
        queue_pair(OPER_MIN, OPER_MIN);
        queue_pair(OPER_MIN, OPER_MAX);
        queue_pair(OPER_MAX, OPER_MIN);
        queue_pair(OPER_MIN, ALL_ONES);
        queue_pair(ALL_ONES, OPER_MIN);
        queue_pair(OPER_MIN, 1);
        queue_pair(1, OPER_MIN);
        queue_pair(OPER_MAX, ALL_ONES);
        queue_pair(ALL_ONES, OPER_MAX);
        queue_pair(OPER_MAX, 1);
        queue_pair('0, OPER_MIN);
        queue_pair(OPER_MIN, '0);
        queue_pair(ALT_LOW, ALT_HIGH);
        queue_pair(ALT_HIGH, ALT_LOW);
        queue_pair(ALT_HIGH, ALT_HIGH);
        queue_pair(-7, 3);
        queue_pair(3, -7);
        queue_pair(12345, ALL_ONES);
        queue_pair(32'h0F0F_0F0F, 32'hF0F0_F0F0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                queue_pair(pick_operand(), pick_operand());
            while (pending_operands.size() > 0)
                @(negedge clk);
        end

        while (in_valid)
            @(negedge clk);
        while (expected_products.size() > 0)
            @(negedge clk);
        repeat (bsm_pkg::WIDTH + 4) @(negedge clk);

        $display("%0d operand pairs sent, %0d products checked, %0d mismatches",
                 pairs_queued, products_checked, mismatch_count);
        $display("pacing phases: free flow, sender gaps, receiver stalls, both");
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/bsm_pkg.sv
rtl/core/bsm_datapath.sv
rtl/core/bsm_ctrl.sv
rtl/core/booth_signed_multiplier.sv
tb/booth_signed_multiplier_test.sv
